/* hdl/gnpm_pkg.sv */
package gnpm_pkg;

	localparam int MAX_TARGETS_DEF = 1024;

	// configuration register indexes
	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_PENALTY   = 2'd1;
	localparam logic [1:0] REG_REUSE     = 2'd2;
	localparam logic [1:0] REG_COUNT     = 2'd3;

	localparam int CFG_W   = 26;
	localparam int CNT_W   = 11;
	localparam int ID_W    = 20;
	localparam int SLOT_W  = 10;
	localparam int COORD_W = 24;
	localparam int SUM_W   = 50;
	localparam int ROOT_W  = 25;
	localparam int REM_W   = 26;
	localparam int COST_W  = 27;
	localparam int IN_W    = 104;
	localparam int OUT_W   = 56;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic [ID_W-1:0]           id;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} tgt_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} isq_t;

	// one digit of the bitwise square root: bring down two radicand bits
	function automatic isq_t isq_step(isq_t cur, logic [1:0] bits);
		logic [REM_W+1:0] r;
		logic [REM_W+1:0] trial;
		isq_t             nxt;
		r     = {cur.rem, bits};
		trial = {1'b0, cur.root, 2'b01};
		if (r >= trial) begin
			nxt.rem  = REM_W'(r - trial);
			nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = REM_W'(r);
			nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
		end
		return nxt;
	endfunction

endpackage

/* hdl/greedy_nearest_point_matcher.sv */
// Greedy nearest-point matcher. Load words (tuser 0) store a target point in a slot and
// clear its used mark. Query words (tuser 1) scan slots 0 to dst_count-1 (capped at
// MAX_TARGETS), one slot read per cycle from the target memory, through a pipeline of a
// difference stage, a squaring stage, a sum stage and a 25-stage square root; the target
// memory has a single read port. The nearest unused target, penalized by sign_penalty
// when its y is not below the source y, wins, lowest slot on a tie; it matches when its
// cost is strictly below match_threshold and is then marked used unless allow_reuse is
// set. Each query returns exactly one result word; loads return none. After reset the
// block clears every used mark before it accepts a word; configuration writes are taken
// at any time but must be made only while the block is idle. A new word is accepted
// while a result still waits on the master side.
module greedy_nearest_point_matcher #(
	parameter int MAX_TARGETS = gnpm_pkg::MAX_TARGETS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [gnpm_pkg::CFG_W-1:0] cfg_data,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// slot[9:0], point_id[29:10], coord_x[53:30], coord_y[77:54], coord_z[101:78], zeros
	input  logic [gnpm_pkg::IN_W-1:0] s_tdata,
	// kind
	input  logic                     s_tuser,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// source_id[19:0], target_id[39:20], target_slot[49:40], zeros
	output logic [gnpm_pkg::OUT_W-1:0] m_tdata,
	// matched
	output logic                     m_tuser
);
	import gnpm_pkg::*;

	localparam int AW    = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
	localparam int CW    = $clog2(MAX_TARGETS + 1);
	localparam int NSTG  = ROOT_W;

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_DONE = 3'd3;

	logic [2:0] state_q;

	// configuration
	logic [CFG_W-1:0] thr_q, pen_q;
	logic             reuse_q;
	logic [CNT_W-1:0] dcnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= CFG_W'(256);
			pen_q   <= CFG_W'(2560);
			reuse_q <= 1'b0;
			dcnt_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD: thr_q   <= cfg_data;
				REG_PENALTY:   pen_q   <= cfg_data;
				REG_REUSE:     reuse_q <= cfg_data[0];
				REG_COUNT:     dcnt_q  <= cfg_data[CNT_W-1:0];
				default:       ;
			endcase
		end
	end

	// input word fields
	logic [SLOT_W-1:0]         in_slot;
	logic [ID_W-1:0]           in_id;
	logic signed [COORD_W-1:0] in_x, in_y, in_z;
	assign in_slot = s_tdata[9:0];
	assign in_id   = s_tdata[29:10];
	assign in_x    = s_tdata[53:30];
	assign in_y    = s_tdata[77:54];
	assign in_z    = s_tdata[101:78];

	logic        in_acc;
	logic        load_ok;
	logic [31:0] dcnt32;
	logic [CW-1:0] cnt_eff;
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign load_ok  = (32'(in_slot) < 32'(MAX_TARGETS));
	assign dcnt32   = 32'(dcnt_q);
	assign cnt_eff  = (dcnt32 > 32'(MAX_TARGETS)) ? CW'(MAX_TARGETS) : CW'(dcnt32);

	// query context
	logic [ID_W-1:0]           src_id_q;
	logic signed [COORD_W-1:0] sx_q, sy_q, sz_q;
	logic [CW-1:0]             addr_q, cnt_q;
	logic [AW-1:0]             clr_q;

	// best candidate so far
	logic              found_q;
	logic [COST_W-1:0] best_cost_q;
	logic [AW-1:0]     best_slot_q;
	logic [ID_W-1:0]   best_id_q;

	// memories
	tgt_t tmem [MAX_TARGETS];
	logic umem [MAX_TARGETS];

	logic          issue;
	logic          t_we, u_we, u_wd;
	logic [AW-1:0] t_wa, u_wa;
	logic          hit;
	logic          out_free;

	assign issue    = (state_q == ST_SCAN) && (addr_q < cnt_q);
	assign hit      = found_q && (best_cost_q < {1'b0, thr_q});
	assign out_free = !m_tvalid || m_tready;

	always_comb begin
		t_we = 1'b0;
		t_wa = AW'(in_slot);
		u_we = 1'b0;
		u_wa = AW'(in_slot);
		u_wd = 1'b0;
		priority if (state_q == ST_CLR) begin
			u_we = 1'b1;
			u_wa = clr_q;
		end else if (in_acc && s_tuser == KIND_LOAD && load_ok) begin
			t_we = 1'b1;
			u_we = 1'b1;
		end else if (state_q == ST_DONE && out_free && hit && !reuse_q) begin
			// claim the winner
			u_we = 1'b1;
			u_wa = best_slot_q;
			u_wd = 1'b1;
		end else begin
			u_we = 1'b0;
		end
	end

	tgt_t tgt_s1;
	logic used_s1;

	always_ff @(posedge clk) begin
		if (t_we)
			tmem[t_wa] <= '{id: in_id, x: in_x, y: in_y, z: in_z};
		tgt_s1 <= tmem[addr_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (u_we)
			umem[u_wa] <= u_wd;
		used_s1 <= umem[addr_q[AW-1:0]];
	end

	// distance pipeline
	logic                v_s1, v_s2, v_s3;
	logic [AW-1:0]       slot_s1, slot_s2, slot_s3;
	logic                skip_s2, skip_s3, pen_s2, pen_s3;
	logic [ID_W-1:0]     id_s2, id_s3;
	logic [COORD_W-1:0]  ax_s2, ay_s2, az_s2;
	logic [2*COORD_W-1:0] qx_s3, qy_s3, qz_s3;

	logic [NSTG:0]       iv_s;
	logic [SUM_W-1:0]    irad_s [NSTG+1];
	isq_t                isq_s  [NSTG+1];
	logic                iskip_s [NSTG+1];
	logic                ipen_s  [NSTG+1];
	logic [ID_W-1:0]     iid_s   [NSTG+1];
	logic [AW-1:0]       islot_s [NSTG+1];

	logic signed [COORD_W:0] dx, dy, dz;
	assign dx = 25'(tgt_s1.x) - 25'(sx_q);
	assign dy = 25'(tgt_s1.y) - 25'(sy_q);
	assign dz = 25'(tgt_s1.z) - 25'(sz_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			iv_s <= '0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			iv_s <= {iv_s[NSTG-1:0], v_s3};
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= addr_q[AW-1:0];
		// differences and magnitudes
		ax_s2   <= COORD_W'(dx[COORD_W] ? -dx : dx);
		ay_s2   <= COORD_W'(dy[COORD_W] ? -dy : dy);
		az_s2   <= COORD_W'(dz[COORD_W] ? -dz : dz);
		pen_s2  <= (tgt_s1.y >= sy_q);
		skip_s2 <= used_s1;
		id_s2   <= tgt_s1.id;
		slot_s2 <= slot_s1;
		// squares
		qx_s3   <= ax_s2 * ax_s2;
		qy_s3   <= ay_s2 * ay_s2;
		qz_s3   <= az_s2 * az_s2;
		pen_s3  <= pen_s2;
		skip_s3 <= skip_s2;
		id_s3   <= id_s2;
		slot_s3 <= slot_s2;
		// sum feeds the root pipeline
		irad_s[0]  <= SUM_W'(qx_s3) + SUM_W'(qy_s3) + SUM_W'(qz_s3);
		isq_s[0]   <= '0;
		iskip_s[0] <= skip_s3;
		ipen_s[0]  <= pen_s3;
		iid_s[0]   <= id_s3;
		islot_s[0] <= slot_s3;
		for (int k = 0; k < NSTG; k++) begin
			isq_s[k+1]   <= isq_step(isq_s[k], irad_s[k][SUM_W-1:SUM_W-2]);
			irad_s[k+1]  <= {irad_s[k][SUM_W-3:0], 2'b00};
			iskip_s[k+1] <= iskip_s[k];
			ipen_s[k+1]  <= ipen_s[k];
			iid_s[k+1]   <= iid_s[k];
			islot_s[k+1] <= islot_s[k];
		end
	end

	logic [COST_W-1:0] cost;
	logic              busy;
	assign cost = COST_W'(isq_s[NSTG].root) + (ipen_s[NSTG] ? COST_W'(pen_q) : '0);
	assign busy = v_s1 || v_s2 || v_s3 || (|iv_s);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLR;
			clr_q    <= '0;
			addr_q   <= '0;
			cnt_q    <= '0;
			found_q  <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			// raise valid when a result retires, drop it once taken
			if (state_q == ST_DONE && out_free)
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(MAX_TARGETS - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_acc && s_tuser == KIND_QUERY) begin
						addr_q  <= '0;
						cnt_q   <= cnt_eff;
						found_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue)
						addr_q <= addr_q + 1'b1;
					else if (!busy)
						state_q <= ST_DONE;
					if (iv_s[NSTG] && !iskip_s[NSTG] && (!found_q || cost < best_cost_q))
						found_q <= 1'b1;
				end
				ST_DONE: begin
					// hold until the output register is free
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			src_id_q <= in_id;
			sx_q     <= in_x;
			sy_q     <= in_y;
			sz_q     <= in_z;
		end
		if (state_q == ST_SCAN && iv_s[NSTG] && !iskip_s[NSTG]
			&& (!found_q || cost < best_cost_q)) begin
			best_cost_q <= cost;
			best_slot_q <= islot_s[NSTG];
			best_id_q   <= iid_s[NSTG];
		end
		if (state_q == ST_DONE && out_free) begin
			m_tuser <= hit;
			m_tdata <= {6'b0,
				hit ? SLOT_W'(32'(best_slot_q)) : SLOT_W'(0),
				hit ? best_id_q : ID_W'(0),
				src_id_q};
		end
	end

	// a used mark is set only when a query retires with a match
	a_claim_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(u_we && u_wd) |-> (state_q == ST_DONE && hit && !reuse_q))
		else $error("used mark set outside a matching query");

	// the distance pipeline drains before a result is produced
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE || state_q == ST_IDLE) |-> !busy)
		else $error("distance pipeline busy outside scan");

	// an unmatched result carries zero target fields
	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[49:20] == '0))
		else $error("unmatched result with nonzero target");

	// a query word always starts a scan
	a_query_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_tuser == KIND_QUERY) |=> (state_q == ST_SCAN))
		else $error("query accepted without scan");

endmodule

/* tb/sv/tb_greedy_nearest_point_matcher.sv */
module tb_greedy_nearest_point_matcher;
	import gnpm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int SETTLE_CYCLES  = 64;
	localparam int FILL_SLOTS     = 64;
	localparam logic [CFG_W-1:0] CFG_MAX = '1;
	localparam logic signed [COORD_W-1:0] C_MAX = 24'sh7FFFFF;
	localparam logic signed [COORD_W-1:0] C_MIN = -24'sh800000;

	typedef struct {
		logic                      kind;
		logic [SLOT_W-1:0]         slot;
		logic [ID_W-1:0]           pid;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} point_word_t;

	typedef struct packed {
		logic              matched;
		logic [ID_W-1:0]   source_id;
		logic [ID_W-1:0]   target_id;
		logic [SLOT_W-1:0] target_slot;
	} pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_THRESHOLD;
	logic [CFG_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic m_tuser;

	// mirror of the block's registers and target memory
	logic [CFG_W-1:0]          thr_q, pen_q;
	logic                      reuse_q;
	logic [CNT_W-1:0]          count_q;
	logic signed [COORD_W-1:0] tx [MAX_TARGETS_DEF];
	logic signed [COORD_W-1:0] ty [MAX_TARGETS_DEF];
	logic signed [COORD_W-1:0] tz [MAX_TARGETS_DEF];
	logic [ID_W-1:0]           tid [MAX_TARGETS_DEF];
	logic                      used [MAX_TARGETS_DEF];

	point_word_t pending_words[$];
	pair_t       expected_pairs[$];
	int          err_count = 0;
	int          idle_cycles = 0;
	int          cyc = 0;

	greedy_nearest_point_matcher dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Integer square root, two radicand bits per step.
	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned root = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= root + b) begin
				n -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	function automatic longint unsigned sq(logic signed [COORD_W-1:0] a,
			logic signed [COORD_W-1:0] b);
		longint d;
		d = longint'(a) - longint'(b);
		return longint'(d * d);
	endfunction

	// Apply one accepted word to the mirror; queries queue the pair they should produce.
	function automatic void match_word(point_word_t w);
		int              n;
		bit              found;
		longint unsigned cost, best_cost;
		int              best;
		pair_t           p;
		if (w.kind == KIND_LOAD) begin
			tx[w.slot] = w.x;
			ty[w.slot] = w.y;
			tz[w.slot] = w.z;
			tid[w.slot] = w.pid;
			used[w.slot] = 1'b0;
			return;
		end
		n = (count_q > MAX_TARGETS_DEF) ? MAX_TARGETS_DEF : int'(count_q);
		found = 0;
		best_cost = 0;
		best = 0;
		for (int j = 0; j < n; j++) begin
			if (used[j])
				continue;
			cost = int_sqrt(sq(tx[j], w.x) + sq(ty[j], w.y) + sq(tz[j], w.z));
			if (ty[j] >= w.y)
				cost += pen_q;
			if (!found || cost < best_cost) begin
				found = 1;
				best_cost = cost;
				best = j;
			end
		end
		p.source_id = w.pid;
		p.matched = found && best_cost < thr_q;
		p.target_id = p.matched ? tid[best] : '0;
		p.target_slot = p.matched ? SLOT_W'(best) : '0;
		if (p.matched && !reuse_q)
			used[best] = 1'b1;
		expected_pairs = {expected_pairs, p};
	endfunction

	function automatic void add_word(logic kind, int slot, int pid, int x, int y, int z);
		point_word_t w;
		w.kind = kind;
		w.slot = SLOT_W'(slot);
		w.pid = ID_W'(pid);
		w.x = COORD_W'(x);
		w.y = COORD_W'(y);
		w.z = COORD_W'(z);
		pending_words = {pending_words, w};
	endfunction

	// Wait until the block has drained, then let any pending scan settle.
	task automatic drain();
		while (pending_words.size() != 0 || expected_pairs.size() != 0 || s_tvalid)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_THRESHOLD: thr_q = val;
			REG_PENALTY:   pen_q = val;
			REG_REUSE:     reuse_q = val[0];
			default:       count_q = val[CNT_W-1:0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_regs(logic [CFG_W-1:0] thr, logic [CFG_W-1:0] pen, logic reuse,
			int count);
		drain();
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_PENALTY, pen);
		write_reg(REG_REUSE, CFG_W'(reuse));
		write_reg(REG_COUNT, CFG_W'(count));
	endtask

	function automatic int jitter(int base, int spread);
		return base + $urandom_range(2 * spread) - spread;
	endfunction

	// One random phase: a point cloud around a random center, queries near it.
	task automatic random_phase();
		int center_x, center_y, center_z, spread, count, k;
		logic [CFG_W-1:0] thr, pen;
		center_x = $urandom;
		center_y = $urandom;
		center_z = $urandom;
		spread = 1 << $urandom_range(3, 12);
		count = $urandom_range(1, 48);
		k = $urandom_range(9);
		thr = (k == 0) ? '0 : (k == 1) ? CFG_MAX : CFG_W'($urandom_range(4 * spread));
		k = $urandom_range(9);
		pen = (k == 0) ? '0 : (k == 1) ? CFG_MAX : CFG_W'($urandom_range(2 * spread));
		if ($urandom_range(19) == 0)
			count = 0;
		set_regs(thr, pen, $urandom_range(1), count);
		repeat (26) begin
			k = $urandom_range(99);
			if (k < 10) begin
				// noise: fully random word
				add_word($urandom_range(1), $urandom, $urandom, $urandom, $urandom, $urandom);
			end else if (k < 55) begin
				add_word(KIND_LOAD, $urandom_range(count + 3 < 1023 ? count + 3 : 1023),
						$urandom, jitter(center_x, spread), jitter(center_y, spread),
						jitter(center_z, spread));
			end else begin
				add_word(KIND_QUERY, $urandom, $urandom, jitter(center_x, spread),
						jitter(center_y, spread), jitter(center_z, spread));
			end
		end
	endtask

	// Driver: advance to the next word when the current one is taken or none is held.
	always @(posedge clk or negedge arst_n) begin
		point_word_t w;
		bit calm;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			m_tready <= 1'b0;
		end else begin
			calm = (cyc % 3000) < 700;
			m_tready <= calm || ($urandom_range(99) >= 26);
			if (!s_tvalid || s_tready) begin
				if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 26)) begin
					w = pending_words.pop_front();
					s_tdata <= {2'b00, w.z, w.y, w.x, w.pid, w.slot};
					s_tuser <= w.kind;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: predict on each accepted input word, check each accepted result word.
	always @(posedge clk) begin
		point_word_t w;
		pair_t exp_p, got;
		cyc <= cyc + 1;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
		if (s_tvalid && s_tready) begin
			{w.z, w.y, w.x, w.pid, w.slot} = s_tdata[IN_W-3:0];
			w.kind = s_tuser;
			match_word(w);
		end
		if (m_tvalid && m_tready) begin
			got.matched = m_tuser;
			{got.target_slot, got.target_id, got.source_id} = m_tdata[49:0];
			if (expected_pairs.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("unexpected result word: src %0h tgt %0h slot %0d m %0b",
							got.source_id, got.target_id, got.target_slot, got.matched);
			end else begin
				exp_p = expected_pairs.pop_front();
				if (got != exp_p) begin
					err_count++;
					if (err_count <= 10)
						$display({"mismatch: exp m %0b src %0h tgt %0h slot %0d, ",
								"got m %0b src %0h tgt %0h slot %0d"},
								exp_p.matched, exp_p.source_id, exp_p.target_id,
								exp_p.target_slot, got.matched, got.source_id,
								got.target_id, got.target_slot);
				end
			end
		end
	end

	initial begin
		thr_q = 256;
		pen_q = 2560;
		reuse_q = 1'b0;
		count_q = '0;
		foreach (used[i])
			used[i] = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// no candidate with a zero count
		add_word(KIND_QUERY, 0, 1, 0, 0, 0);
		set_regs(256, 2560, 1'b0, 4);
		add_word(KIND_LOAD, 0, 20'hFFFFF, C_MAX, C_MAX, C_MAX);
		add_word(KIND_LOAD, 1, 0, C_MIN, C_MIN, C_MIN);
		add_word(KIND_LOAD, 2, 5, -100, -100, 0);
		add_word(KIND_LOAD, 3, 6, 100, -100, 0);
		// tie: lowest slot first, then the other, then nothing within range
		add_word(KIND_QUERY, 1023, 2, 0, 0, 0);
		add_word(KIND_QUERY, 0, 3, 0, 0, 0);
		add_word(KIND_QUERY, 0, 4, 0, 0, 0);
		// reload clears the used mark; equal y takes the penalty
		add_word(KIND_LOAD, 2, 5, -100, -100, 0);
		add_word(KIND_QUERY, 0, 7, -100, -100, 0);

		set_regs(CFG_MAX, 0, 1'b1, 4);
		add_word(KIND_QUERY, 0, 8, C_MAX, C_MAX, C_MAX);
		add_word(KIND_QUERY, 0, 9, C_MAX, C_MAX, C_MAX);
		add_word(KIND_QUERY, 0, 20'hFFFFF, C_MIN, C_MIN, C_MIN);
		add_word(KIND_QUERY, 0, 10, C_MIN, C_MAX, 0);

		// fill the low slots, then scan all of them
		set_regs(CFG_MAX, CFG_MAX, 1'b0, 4);
		for (int s = 0; s < FILL_SLOTS; s++)
			add_word(KIND_LOAD, s, $urandom, jitter(0, 4096), jitter(0, 4096),
					jitter(0, 4096));
		set_regs(CFG_MAX, CFG_MAX, 1'b0, FILL_SLOTS);
		add_word(KIND_QUERY, 0, 11, 0, 8388607, 0);
		add_word(KIND_QUERY, 0, 12, 0, 0, 0);
		set_regs(4096, 100, 1'b0, FILL_SLOTS);
		add_word(KIND_QUERY, 0, 13, 0, 0, 0);
		add_word(KIND_QUERY, 0, 14, 0, 8388607, 0);

		repeat (19)
			random_phase();

		while (pending_words.size() != 0 || expected_pairs.size() != 0 || s_tvalid)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_pairs.size() != 0)
			err_count++;
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
